@@ rtl/quadratic_root_solver_macros.svh @@
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms for the solver checker.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

// Next-cycle implication that also holds through reset.
`define QRS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

`endif

@@ rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Default widths and the case codes of the solver result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int unsigned WORD_BITS_DEF     = 32;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CASE_ALL_ZERO = 3'd0,
        CASE_NO_SOL   = 3'd1,
        CASE_LINEAR   = 3'd2,
        CASE_TWO_REAL = 3'd3,
        CASE_DOUBLE   = 3'd4,
        CASE_COMPLEX  = 3'd5
    } t_root_case;

endpackage

@@ rtl/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver
// Throughput is one transaction per cycle while o_stall is low; the cell chains are the
// square root (WORD_BITS+1 cells) and the two dividers (WORD_BITS+FRACTION_BITS+2 cells).
// A skid register behind the output register holds one result while the output stalls.
// Synchronous active-low reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_root_solver #(
    parameter int WORD_BITS     = qrs_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WORD_BITS-1:0] i_coef_quad,
    input  logic signed [WORD_BITS-1:0] i_coef_lin,
    input  logic signed [WORD_BITS-1:0] i_coef_const,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_root_case,
    output logic signed [WORD_BITS-1:0] o_first_real,
    output logic signed [WORD_BITS-1:0] o_second_real,
    output logic signed [WORD_BITS-1:0] o_first_imag,
    output logic signed [WORD_BITS-1:0] o_second_imag,
    output logic                        o_range_overflow
);

    import qrs_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int RAD_W = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int NUM_W = W + 2;
    localparam int DEN_W = W + 1;
    localparam int QUO_W = NUM_W + F;
    localparam int SQS_W = 3 * W + 4;
    localparam int DS0_W = 4;
    localparam int DS1_W = 1;

    function automatic logic [NUM_W:0] sm_add(input logic na, input logic [NUM_W-1:0] a,
                                              input logic nb, input logic [NUM_W-1:0] b);
        logic [NUM_W-1:0] r;
        logic             nr;
        if (na == nb) begin
            r  = a + b;
            nr = na;
        end else if (a >= b) begin
            r  = a - b;
            nr = na;
        end else begin
            r  = b - a;
            nr = nb;
        end
        if (r == '0) begin
            nr = 1'b0;
        end
        return {nr, r};
    endfunction

    function automatic logic [W:0] clamp(input logic [QUO_W-1:0] q, input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] v;
        logic         ovf;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        ovf = (q > {{(QUO_W-W){1'b0}}, lim});
        v   = ovf ? lim : q[W-1:0];
        return {ovf, (neg ? (~v + 1'b1) : v)};
    endfunction

    logic en;

    // Stage A: magnitudes and signs.
    logic             r_a_valid;
    logic [W-1:0]     r_a_ma, r_a_mb, r_a_mc;
    logic             r_a_na, r_a_nb, r_a_nc;

    // Stage B: products.
    logic             r_b_valid;
    logic [2*W-1:0]   r_b_bb, r_b_ac;
    logic [W-1:0]     r_b_ma, r_b_mb, r_b_mc;
    logic             r_b_na, r_b_nb, r_b_nc;

    // Stage C: discriminant in sign-magnitude form.
    logic             r_c_valid;
    logic [RAD_W-1:0] r_c_delta;
    logic             r_c_dneg;
    logic [W-1:0]     r_c_ma, r_c_mb, r_c_mc;
    logic             r_c_na, r_c_nb, r_c_nc;
    logic [RAD_W-1:0] c_bb, c_ac4;

    // Square root chain.
    logic              sq_valid [0:ROOT_W];
    logic [RAD_W-1:0]  sq_rad   [0:ROOT_W];
    logic [ROOT_W+1:0] sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root  [0:ROOT_W];
    logic [SQS_W-1:0]  sq_side  [0:ROOT_W];

    // Stage E: numerators and denominators.
    logic             r_e_valid;
    logic [NUM_W-1:0] r_e_num0, r_e_num1;
    logic [DEN_W-1:0] r_e_den0, r_e_den1;
    logic [DS0_W-1:0] r_e_side0;
    logic [DS1_W-1:0] r_e_side1;
    logic [NUM_W-1:0] n_num0, n_num1;
    logic [DEN_W-1:0] n_den0, n_den1;
    t_root_case       n_case;
    logic             n_neg0, n_neg1;
    logic [W-1:0]     e_ma, e_mb, e_mc;
    logic             e_na, e_nb, e_nc, e_dneg, e_negb;
    logic [ROOT_W-1:0] e_s;
    logic [NUM_W-1:0] e_mbx, e_sx;
    logic [NUM_W:0]   e_n1, e_n2;

    // Divider chains.
    logic             d0_valid [0:QUO_W];
    logic [QUO_W-1:0] d0_xq    [0:QUO_W];
    logic [DEN_W-1:0] d0_rem   [0:QUO_W];
    logic [DEN_W-1:0] d0_den   [0:QUO_W];
    logic [DS0_W-1:0] d0_side  [0:QUO_W];
    logic             d1_valid [0:QUO_W];
    logic [QUO_W-1:0] d1_xq    [0:QUO_W];
    logic [DEN_W-1:0] d1_rem   [0:QUO_W];
    logic [DEN_W-1:0] d1_den   [0:QUO_W];
    logic [DS1_W-1:0] d1_side  [0:QUO_W];

    // Result formatting.
    t_root_case       t_case;
    logic             t_neg0, t_neg1;
    logic [W:0]       t_c0, t_c1, t_c1n;
    logic [2:0]       n_res_case;
    logic [W-1:0]     n_res_fr, n_res_sr, n_res_fi, n_res_si;
    logic             n_res_ovf;

    logic             r_out_valid;
    logic [2:0]       r_out_case;
    logic [W-1:0]     r_out_fr, r_out_sr, r_out_fi, r_out_si;
    logic             r_out_ovf;
    logic             r_skid_valid;
    logic [2:0]       r_skid_case;
    logic [W-1:0]     r_skid_fr, r_skid_sr, r_skid_fi, r_skid_si;
    logic             r_skid_ovf;

    assign en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_e_valid <= sq_valid[ROOT_W];
        end
    end

    always_comb begin
        c_bb  = {2'b00, r_b_bb};
        c_ac4 = {r_b_ac, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_na <= i_coef_quad[W-1];
            r_a_nb <= i_coef_lin[W-1];
            r_a_nc <= i_coef_const[W-1];
            r_a_ma <= i_coef_quad[W-1] ? W'(-i_coef_quad) : W'(i_coef_quad);
            r_a_mb <= i_coef_lin[W-1] ? W'(-i_coef_lin) : W'(i_coef_lin);
            r_a_mc <= i_coef_const[W-1] ? W'(-i_coef_const) : W'(i_coef_const);

            r_b_bb <= r_a_mb * r_a_mb;
            r_b_ac <= r_a_ma * r_a_mc;
            r_b_ma <= r_a_ma;
            r_b_mb <= r_a_mb;
            r_b_mc <= r_a_mc;
            r_b_na <= r_a_na;
            r_b_nb <= r_a_nb;
            r_b_nc <= r_a_nc;

            if (r_b_na != r_b_nc) begin
                r_c_delta <= c_bb + c_ac4;
                r_c_dneg  <= 1'b0;
            end else if (c_bb >= c_ac4) begin
                r_c_delta <= c_bb - c_ac4;
                r_c_dneg  <= 1'b0;
            end else begin
                r_c_delta <= c_ac4 - c_bb;
                r_c_dneg  <= 1'b1;
            end
            r_c_ma <= r_b_ma;
            r_c_mb <= r_b_mb;
            r_c_mc <= r_b_mc;
            r_c_na <= r_b_na;
            r_c_nb <= r_b_nb;
            r_c_nc <= r_b_nc;
        end
    end

    assign sq_valid[0] = r_c_valid;
    assign sq_rad[0]   = r_c_delta;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {r_c_ma, r_c_mb, r_c_mc, r_c_na, r_c_nb, r_c_nc, r_c_dneg};

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .RAD_W  (RAD_W),
            .ROOT_W (ROOT_W),
            .SIDE_W (SQS_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    always_comb begin
        e_ma   = sq_side[ROOT_W][SQS_W-1 -: W];
        e_mb   = sq_side[ROOT_W][SQS_W-W-1 -: W];
        e_mc   = sq_side[ROOT_W][SQS_W-2*W-1 -: W];
        e_na   = sq_side[ROOT_W][3];
        e_nb   = sq_side[ROOT_W][2];
        e_nc   = sq_side[ROOT_W][1];
        e_dneg = sq_side[ROOT_W][0];
        e_s    = sq_root[ROOT_W];
        e_negb = (e_mb != '0) && !e_nb;
        e_mbx  = {2'b00, e_mb};
        e_sx   = {1'b0, e_s};
        e_n1   = sm_add(e_negb, e_mbx, 1'b0, e_sx);
        e_n2   = sm_add(e_negb, e_mbx, 1'b1, e_sx);
        n_den0 = {e_ma, 1'b0};
        n_den1 = {e_ma, 1'b0};
        n_num1 = e_sx;
        n_neg1 = e_na;
        if (e_ma == '0) begin
            n_num0 = {2'b00, e_mc};
            n_den0 = {1'b0, e_mb};
            n_neg0 = ((e_mc != '0) && !e_nc) != e_nb;
            if (e_mb != '0) begin
                n_case = CASE_LINEAR;
            end else if (e_mc != '0) begin
                n_case = CASE_NO_SOL;
            end else begin
                n_case = CASE_ALL_ZERO;
            end
        end else if (e_s == '0) begin
            n_case = CASE_DOUBLE;
            n_num0 = e_mbx;
            n_neg0 = e_negb != e_na;
        end else if (!e_dneg) begin
            n_case = CASE_TWO_REAL;
            n_num0 = e_n1[NUM_W-1:0];
            n_neg0 = e_n1[NUM_W] != e_na;
            n_num1 = e_n2[NUM_W-1:0];
            n_neg1 = e_n2[NUM_W] != e_na;
        end else begin
            n_case = CASE_COMPLEX;
            n_num0 = e_mbx;
            n_neg0 = e_negb != e_na;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_num0  <= n_num0;
            r_e_num1  <= n_num1;
            r_e_den0  <= n_den0;
            r_e_den1  <= n_den1;
            r_e_side0 <= {n_case, n_neg0};
            r_e_side1 <= n_neg1;
        end
    end

    assign d0_valid[0] = r_e_valid;
    assign d0_xq[0]    = {r_e_num0, {F{1'b0}}};
    assign d0_rem[0]   = '0;
    assign d0_den[0]   = r_e_den0;
    assign d0_side[0]  = r_e_side0;
    assign d1_valid[0] = r_e_valid;
    assign d1_xq[0]    = {r_e_num1, {F{1'b0}}};
    assign d1_rem[0]   = '0;
    assign d1_den[0]   = r_e_den1;
    assign d1_side[0]  = r_e_side1;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        qrs_div_cell #(
            .QUO_W  (QUO_W),
            .DEN_W  (DEN_W),
            .SIDE_W (DS0_W)
        ) u_lane0 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d0_valid[k]),
            .i_xq    (d0_xq[k]),
            .i_rem   (d0_rem[k]),
            .i_den   (d0_den[k]),
            .i_side  (d0_side[k]),
            .o_valid (d0_valid[k+1]),
            .o_xq    (d0_xq[k+1]),
            .o_rem   (d0_rem[k+1]),
            .o_den   (d0_den[k+1]),
            .o_side  (d0_side[k+1])
        );
        qrs_div_cell #(
            .QUO_W  (QUO_W),
            .DEN_W  (DEN_W),
            .SIDE_W (DS1_W)
        ) u_lane1 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d1_valid[k]),
            .i_xq    (d1_xq[k]),
            .i_rem   (d1_rem[k]),
            .i_den   (d1_den[k]),
            .i_side  (d1_side[k]),
            .o_valid (d1_valid[k+1]),
            .o_xq    (d1_xq[k+1]),
            .o_rem   (d1_rem[k+1]),
            .o_den   (d1_den[k+1]),
            .o_side  (d1_side[k+1])
        );
    end

    always_comb begin
        t_case     = t_root_case'(d0_side[QUO_W][3:1]);
        t_neg0     = d0_side[QUO_W][0];
        t_neg1     = d1_side[QUO_W][0];
        t_c0       = clamp(d0_xq[QUO_W], t_neg0);
        t_c1       = clamp(d1_xq[QUO_W], t_neg1);
        t_c1n      = clamp(d1_xq[QUO_W], !t_neg1);
        n_res_case = t_case;
        n_res_fr   = '0;
        n_res_sr   = '0;
        n_res_fi   = '0;
        n_res_si   = '0;
        n_res_ovf  = 1'b0;
        unique case (t_case)
            CASE_LINEAR, CASE_DOUBLE: begin
                n_res_fr  = t_c0[W-1:0];
                n_res_ovf = t_c0[W];
            end
            CASE_TWO_REAL: begin
                n_res_fr  = t_c0[W-1:0];
                n_res_sr  = t_c1[W-1:0];
                n_res_ovf = t_c0[W] | t_c1[W];
            end
            CASE_COMPLEX: begin
                n_res_fr  = t_c0[W-1:0];
                n_res_sr  = t_c0[W-1:0];
                n_res_fi  = t_c1[W-1:0];
                n_res_si  = t_c1n[W-1:0];
                n_res_ovf = t_c0[W] | t_c1[W] | t_c1n[W];
            end
            default: begin
                n_res_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= d0_valid[QUO_W];
            end
        end else if (d0_valid[QUO_W] && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_case <= r_skid_case;
                r_out_fr   <= r_skid_fr;
                r_out_sr   <= r_skid_sr;
                r_out_fi   <= r_skid_fi;
                r_out_si   <= r_skid_si;
                r_out_ovf  <= r_skid_ovf;
            end else begin
                r_out_case <= n_res_case;
                r_out_fr   <= n_res_fr;
                r_out_sr   <= n_res_sr;
                r_out_fi   <= n_res_fi;
                r_out_si   <= n_res_si;
                r_out_ovf  <= n_res_ovf;
            end
        end else if (en) begin
            r_skid_case <= n_res_case;
            r_skid_fr   <= n_res_fr;
            r_skid_sr   <= n_res_sr;
            r_skid_fi   <= n_res_fi;
            r_skid_si   <= n_res_si;
            r_skid_ovf  <= n_res_ovf;
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_root_case      = r_out_case;
    assign o_first_real     = r_out_fr;
    assign o_second_real    = r_out_sr;
    assign o_first_imag     = r_out_fi;
    assign o_second_imag    = r_out_si;
    assign o_range_overflow = r_out_ovf;

endmodule

@@ rtl/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
    parameter int RAD_W  = 66,
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [ROOT_W+1:0]   i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [RAD_W-1:0]    o_rad,
    output logic [ROOT_W+1:0]   o_rem,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [RAD_W-1:0]  n_rad;

    logic              r_valid;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        rem_sh = {i_rem, i_rad[RAD_W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
        n_rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        n_root = {i_root[ROOT_W-2:0], ge};
        n_rad  = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

@@ rtl/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step producing a single quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_div_cell #(
    parameter int QUO_W  = 50,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [QUO_W-1:0]  i_xq,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_xq,
    output logic [DEN_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_xq;

    logic              r_valid;
    logic [QUO_W-1:0]  r_xq;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        rem_sh = {i_rem, i_xq[QUO_W-1]};
        diff   = rem_sh - {1'b0, i_den};
        ge     = (rem_sh >= {1'b0, i_den});
        n_rem  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        n_xq   = {i_xq[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xq   <= n_xq;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_xq    = r_xq;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

@@ rtl/qrs_checker.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level assertions on the solver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadratic_root_solver_macros.svh"

module qrs_checker #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [2:0]           o_root_case,
    input logic [WORD_BITS-1:0] o_first_real,
    input logic [WORD_BITS-1:0] o_second_real,
    input logic [WORD_BITS-1:0] o_first_imag,
    input logic [WORD_BITS-1:0] o_second_imag,
    input logic                 o_range_overflow
);

    import qrs_pkg::*;

    `QRS_ASSERT_NEXT_ALWAYS(a_reset_clears, !i_rst_n, !o_valid && !o_stall)
    `QRS_ASSERT_NEXT(a_stall_holds, o_valid && i_stall, o_valid && $stable(o_first_real) && $stable(o_root_case))
    `QRS_ASSERT_NOW(a_degenerate_zero, o_valid && (o_root_case == CASE_ALL_ZERO || o_root_case == CASE_NO_SOL), o_first_real == '0 && o_second_real == '0 && !o_range_overflow)
    `QRS_ASSERT_NOW(a_imag_only_complex, o_valid && o_root_case != CASE_COMPLEX, o_first_imag == '0 && o_second_imag == '0)

endmodule

bind quadratic_root_solver qrs_checker #(
    .WORD_BITS (WORD_BITS)
) u_qrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_root_case      (o_root_case),
    .o_first_real     (o_first_real),
    .o_second_real    (o_second_real),
    .o_first_imag     (o_first_imag),
    .o_second_imag    (o_second_imag),
    .o_range_overflow (o_range_overflow)
);
